@@ hw/rtl/mfa_pkg.sv @@
// package for the a-coefficient mode splitting block
// widths, weight table and divide-by-five digit step; no dependencies
`default_nettype none

package mfa_pkg;

    localparam int MAX_DEGREE  = 3;
    localparam int FREQ_W      = 48;
    localparam int DEG_W       = 2;
    localparam int ORD_W       = 3;
    localparam int NUM_TERMS   = 6;
    localparam int WT_W        = 7;
    localparam int WMAG_W      = 6;
    localparam int PROD_W      = FREQ_W + WMAG_W;
    localparam int ACC_W       = 56;
    localparam int DIGIT_W     = 4;
    localparam int DIV_STEPS   = ACC_W / DIGIT_W;
    localparam int IN_TDATA_W  = 344;
    localparam int OUT_TDATA_W = 56;

    localparam logic [2:0] TERM_A1 = 3'd0;
    localparam logic [2:0] TERM_A2 = 3'd1;
    localparam logic [2:0] TERM_A3 = 3'd2;
    localparam logic [2:0] TERM_A4 = 3'd3;
    localparam logic [2:0] TERM_A5 = 3'd4;
    localparam logic [2:0] TERM_A6 = 3'd5;

    typedef struct packed {
        logic                   div5;
        logic signed [WT_W-1:0] w;
    } t_weight;

    typedef struct packed {
        logic [DIGIT_W-1:0] q;
        logic [2:0]         r;
    } t_digit;

    // integer weight of term s for degree l and order m; div5 marks a numerator over five
    function automatic t_weight term_weight(input logic [1:0] l,
                                            input logic signed [2:0] m,
                                            input logic [2:0] s);
        logic [2:0]             neg_m;
        logic [1:0]             mag;
        logic [3:0]             key;
        logic signed [WT_W-1:0] w;
        t_weight                res;
        neg_m = 3'(-m);
        mag   = m[2] ? neg_m[1:0] : m[1:0];
        key   = {l, mag};
        w     = 7'sd0;
        case (s)
            TERM_A1: w = $signed({5'b00000, mag});
            TERM_A2: begin
                case (key)
                    4'b0100: w = -7'sd2;
                    4'b0101: w = 7'sd1;
                    4'b1000: w = -7'sd2;
                    4'b1001: w = -7'sd1;
                    4'b1010: w = 7'sd2;
                    4'b1100: w = -7'sd12;
                    4'b1101: w = -7'sd9;
                    4'b1111: w = 7'sd3;
                    default: w = 7'sd0;
                endcase
            end
            TERM_A3: begin
                case (key)
                    4'b1001: w = -7'sd4;
                    4'b1010: w = 7'sd2;
                    4'b1101: w = -7'sd3;
                    4'b1110: w = -7'sd3;
                    4'b1111: w = 7'sd3;
                    default: w = 7'sd0;
                endcase
            end
            TERM_A4: begin
                case (key)
                    4'b1000: w = 7'sd12;
                    4'b1001: w = -7'sd8;
                    4'b1010: w = 7'sd2;
                    4'b1100: w = 7'sd6;
                    4'b1101: w = 7'sd1;
                    4'b1110: w = -7'sd7;
                    4'b1111: w = 7'sd3;
                    default: w = 7'sd0;
                endcase
            end
            TERM_A5: begin
                case (key)
                    4'b1101: w = 7'sd15;
                    4'b1110: w = -7'sd12;
                    4'b1111: w = 7'sd3;
                    default: w = 7'sd0;
                endcase
            end
            TERM_A6: begin
                case (key)
                    4'b1100: w = -7'sd60;
                    4'b1101: w = 7'sd45;
                    4'b1110: w = -7'sd18;
                    4'b1111: w = 7'sd3;
                    default: w = 7'sd0;
                endcase
            end
            default: w = 7'sd0;
        endcase
        // odd terms flip sign with m
        if (m[2] && (s == TERM_A1 || s == TERM_A3 || s == TERM_A5)) begin
            w = -w;
        end
        res.w    = w;
        res.div5 = (s == TERM_A2) && (l == 2'd3) && !mag[1];
        return res;
    endfunction

    // one radix-16 digit of a divide by five, v below 80
    function automatic t_digit div5_digit(input logic [6:0] v);
        logic [14:0] p;
        logic [6:0]  t;
        t_digit      res;
        p     = 15'(v) * 15'd205;
        res.q = p[13:10];
        t     = v - 7'({res.q, 2'b00}) - 7'(res.q);
        res.r = t[2:0];
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mode_frequencies_from_acoefs.sv @@
// split mode frequencies from a-coefficients, one shared 48x6 multiplier under a sequencer
// depends on mfa_pkg; a request is taken only while the sequencer is idle
// each component passes all six terms through the multiplier, with a divide-by-five pass
// on a2 when l = 3 and |m| <= 1; a full item gives 2l+1 components, the last with tlast
// reset clears the sequencer state and the product and output valid flags; no memory to clear
`default_nettype none

module mode_frequencies_from_acoefs
    import mfa_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // central_freq, degree, coef_a1 .. coef_a6, zero pad
    input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // split_freq, azimuthal_order, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [DEG_W-1:0]         r_l, n_l;
    logic signed [ORD_W-1:0]  r_m, n_m;
    logic [2:0]               r_term, n_term;
    logic signed [FREQ_W-1:0] r_nu0, n_nu0;
    logic signed [FREQ_W-1:0] r_coef [NUM_TERMS];
    logic signed [FREQ_W-1:0] n_coef [NUM_TERMS];
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic                     r_prod_neg, n_prod_neg;
    logic                     r_prod_div, n_prod_div;
    logic                     r_prod_vld, n_prod_vld;
    logic [ACC_W-1:0]         r_div_num, n_div_num;
    logic [ACC_W-1:0]         r_div_quo, n_div_quo;
    logic [2:0]               r_div_rem, n_div_rem;
    logic [3:0]               r_div_cnt, n_div_cnt;
    logic                     r_out_vld, n_out_vld;
    logic [OUT_TDATA_W-1:0]   r_out_data, n_out_data;
    logic                     r_out_last, n_out_last;

    logic signed [FREQ_W-1:0] in_nu0;
    logic [DEG_W-1:0]         in_deg;
    logic [DEG_W-1:0]         in_l;
    logic signed [FREQ_W-1:0] in_coef [NUM_TERMS];
    logic signed [ORD_W-1:0]  l_signed;
    logic signed [ORD_W-1:0]  in_l_signed;
    logic signed [FREQ_W-1:0] coef_sel;
    t_weight                  wt;
    logic [WT_W-1:0]          w_neg;
    logic [WMAG_W-1:0]        w_mag;
    logic [FREQ_W-1:0]        a_neg;
    logic [FREQ_W-1:0]        a_mag;
    logic [PROD_W-1:0]        prod_next;
    logic [ACC_W-1:0]         prod_ext;
    logic signed [ACC_W-1:0]  term_val;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  nu0_ext;
    logic [FREQ_W-1:0]        sat_freq;
    logic                     out_free;
    logic                     is_last;
    t_digit                   digit;
    logic [ACC_W-1:0]         quo_next;

    // input request fields
    always_comb begin
        in_nu0 = $signed(s_axis_tdata[FREQ_W-1:0]);
        in_deg = s_axis_tdata[FREQ_W +: DEG_W];
        for (int i = 0; i < NUM_TERMS; i++) begin
            in_coef[i] = $signed(s_axis_tdata[FREQ_W + DEG_W + FREQ_W*i +: FREQ_W]);
        end
    end

    assign in_l        = (in_deg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : in_deg;
    assign in_l_signed = $signed({1'b0, in_l});
    assign l_signed    = $signed({1'b0, r_l});

    // shared multiply on magnitudes
    assign coef_sel  = r_coef[r_term];
    assign wt        = term_weight(r_l, r_m, r_term);
    assign w_neg     = 7'(-wt.w);
    assign w_mag     = wt.w[WT_W-1] ? w_neg[WMAG_W-1:0] : wt.w[WMAG_W-1:0];
    assign a_neg     = FREQ_W'(-coef_sel);
    assign a_mag     = coef_sel[FREQ_W-1] ? a_neg : coef_sel;
    assign prod_next = a_mag * w_mag;

    // accumulate and saturate
    assign prod_ext = ACC_W'(r_prod);
    assign term_val = r_prod_neg ? $signed(ACC_W'(-prod_ext)) : $signed(prod_ext);
    assign acc_sum  = r_acc + term_val;
    assign nu0_ext  = ACC_W'(r_nu0);

    always_comb begin
        if (r_acc[ACC_W-1:FREQ_W-1] == '0 || r_acc[ACC_W-1:FREQ_W-1] == '1) begin
            sat_freq = r_acc[FREQ_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            sat_freq = {1'b1, {(FREQ_W-1){1'b0}}};
        end else begin
            sat_freq = {1'b0, {(FREQ_W-1){1'b1}}};
        end
    end

    assign out_free = !r_out_vld || m_axis_tready;
    assign is_last  = (r_m == l_signed);

    // divide-by-five digit step
    assign digit    = div5_digit({r_div_rem, r_div_num[ACC_W-1 -: DIGIT_W]});
    assign quo_next = {r_div_quo[ACC_W-DIGIT_W-1:0], digit.q};

    always_comb begin
        n_state    = r_state;
        n_l        = r_l;
        n_m        = r_m;
        n_term     = r_term;
        n_nu0      = r_nu0;
        n_coef     = r_coef;
        n_acc      = r_acc;
        n_prod     = r_prod;
        n_prod_neg = r_prod_neg;
        n_prod_div = r_prod_div;
        n_prod_vld = r_prod_vld;
        n_div_num  = r_div_num;
        n_div_quo  = r_div_quo;
        n_div_rem  = r_div_rem;
        n_div_cnt  = r_div_cnt;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_nu0      = in_nu0;
                    n_coef     = in_coef;
                    n_l        = in_l;
                    n_m        = ORD_W'(-in_l_signed);
                    n_term     = TERM_A1;
                    n_acc      = ACC_W'(in_nu0);
                    n_prod_vld = 1'b0;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                if (r_prod_vld && r_prod_div) begin
                    n_div_num  = prod_ext + ACC_W'(2);
                    n_div_quo  = '0;
                    n_div_rem  = 3'd0;
                    n_div_cnt  = 4'd0;
                    n_prod_vld = 1'b0;
                    n_state    = S_DIV;
                end else begin
                    if (r_prod_vld) begin
                        n_acc = acc_sum;
                    end
                    if (r_term < 3'(NUM_TERMS)) begin
                        n_prod     = prod_next;
                        n_prod_neg = coef_sel[FREQ_W-1] ^ wt.w[WT_W-1];
                        n_prod_div = wt.div5;
                        n_prod_vld = 1'b1;
                        n_term     = 3'(r_term + 3'd1);
                    end else begin
                        n_prod_vld = 1'b0;
                        if (!r_prod_vld && out_free) begin
                            n_out_vld  = 1'b1;
                            n_out_data = {{(OUT_TDATA_W-FREQ_W-ORD_W){1'b0}}, r_m, sat_freq};
                            n_out_last = is_last;
                            n_term     = TERM_A1;
                            n_acc      = nu0_ext;
                            n_m        = r_m + 3'sd1;
                            if (is_last) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                n_div_num = r_div_num << DIGIT_W;
                n_div_quo = quo_next;
                n_div_rem = digit.r;
                n_div_cnt = 4'(r_div_cnt + 4'd1);
                if (r_div_cnt == 4'(DIV_STEPS - 1)) begin
                    n_prod     = quo_next[PROD_W-1:0];
                    n_prod_div = 1'b0;
                    n_prod_vld = 1'b1;
                    n_state    = S_CALC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_prod_vld <= n_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l        <= n_l;
        r_m        <= n_m;
        r_term     <= n_term;
        r_nu0      <= n_nu0;
        r_coef     <= n_coef;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_prod_neg <= n_prod_neg;
        r_prod_div <= n_prod_div;
        r_div_num  <= n_div_num;
        r_div_quo  <= n_div_quo;
        r_div_rem  <= n_div_rem;
        r_div_cnt  <= n_div_cnt;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    ap_div_holds_no_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_prod_vld)
        else $error("product pending during divide");

    ap_request_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (r_state == S_CALC) && (r_term == TERM_A1) && !r_prod_vld)
        else $error("request did not start a fresh component");

    ap_div_only_for_a2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && r_prod_vld && r_prod_div) |->
            (r_l == 2'd3) && (r_term == TERM_A3))
        else $error("divide requested outside the a2 term of degree three");

    ap_order_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_m <= l_signed) && (r_m >= -l_signed))
        else $error("azimuthal order out of range");
`endif

endmodule

`default_nettype wire

@@ bench/mfa_split_checker.sv @@
// checker for mode_frequencies_from_acoefs: watches both stream channels,
// predicts the split components of every request and compares them in order
// depends on mfa_pkg for widths and the degree limit
module mfa_split_checker
    import mfa_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_req_valid,
    input  wire                    i_req_ready,
    input  wire  [IN_TDATA_W-1:0]  i_req_data,
    input  wire                    i_res_valid,
    input  wire                    i_res_ready,
    input  wire  [OUT_TDATA_W-1:0] i_res_data,
    input  wire                    i_res_last,
    output int                     o_pending,
    output int                     o_fail_count
);

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [FREQ_W-1:0] freq;
        logic signed [ORD_W-1:0]  order;
        logic                     last;
    } t_component;

    localparam t_wide SAT_HI = (t_wide'(1) <<< (FREQ_W - 1)) - 1;
    localparam t_wide SAT_LO = -(t_wide'(1) <<< (FREQ_W - 1));

    t_component expected_components[$];
    t_component seen;
    t_component wanted;
    int         fail_total = 0;

    // coef * num / den rounded half away from zero, nothing where den is zero
    function automatic t_wide round_weighted(input t_wide coef, input longint num,
                                             input longint den);
        t_wide prod;
        t_wide mag;
        t_wide dmag;
        if (den == 0 || num == 0 || coef == 0) begin
            return 0;
        end
        prod = coef * t_wide'(num);
        mag  = (prod < 0) ? -prod : prod;
        dmag = (den < 0) ? -t_wide'(den) : t_wide'(den);
        mag  = (mag + dmag / 2) / dmag;
        return ((prod < 0) != (den < 0)) ? -mag : mag;
    endfunction

    function automatic void split_components(input logic [IN_TDATA_W-1:0] req);
        t_wide      nu0;
        t_wide      coef[NUM_TERMS];
        t_wide      total;
        longint     deg, ll1, d2, d3, d4, d5;
        longint     m, m2, m3, m4, m5, m6;
        longint     num[NUM_TERMS];
        longint     den[NUM_TERMS];
        t_component comp;
        nu0 = $signed(req[FREQ_W-1:0]);
        deg = req[FREQ_W +: DEG_W];
        for (int s = 0; s < NUM_TERMS; s++) begin
            coef[s] = $signed(req[FREQ_W + DEG_W + s * FREQ_W +: FREQ_W]);
        end
        if (deg > MAX_DEGREE) begin
            deg = MAX_DEGREE;
        end
        ll1 = deg * (deg + 1);
        d2  = deg * deg;
        d3  = d2 * deg;
        d4  = d3 * deg;
        d5  = d4 * deg;
        den[0] = 1;
        den[1] = (deg > 0) ? (2 * deg - 1) : 0;
        den[2] = (deg > 1) ? ((deg - 1) * (2 * deg - 1)) : 0;
        den[3] = 2 * (deg - 1) * (2 * deg - 1) * (2 * deg - 3);
        den[4] = 8 * (4 * d4 - 20 * d3 + 35 * d2 - 25 * deg + 6);
        den[5] = 64 * d5 - 480 * d4 + 1360 * d3 - 1800 * d2 + 1096 * deg - 240;
        for (m = -deg; m <= deg; m++) begin
            m2 = m * m;
            m3 = m2 * m;
            m4 = m3 * m;
            m5 = m4 * m;
            m6 = m5 * m;
            num[0] = m;
            num[1] = 3 * m2 - ll1;
            num[2] = 5 * m3 - (3 * ll1 - 1) * m;
            num[3] = 35 * m4 - 5 * (6 * ll1 - 5) * m2 + 3 * ll1 * (ll1 - 2);
            num[4] = 252 * m5 - 140 * (2 * ll1 - 3) * m3
                   + (20 * ll1 * (3 * ll1 - 10) + 48) * m;
            num[5] = 924 * m6 - 420 * (3 * ll1 - 7) * m4
                   + 84 * (5 * ll1 * ll1 - 25 * ll1 + 14) * m2
                   - 20 * ll1 * (ll1 * ll1 - 8 * ll1 + 12);
            total = nu0;
            for (int s = 0; s < NUM_TERMS; s++) begin
                total += round_weighted(coef[s], num[s], den[s]);
            end
            if (total > SAT_HI) begin
                total = SAT_HI;
            end
            if (total < SAT_LO) begin
                total = SAT_LO;
            end
            comp.freq  = total[FREQ_W-1:0];
            comp.order = m[ORD_W-1:0];
            comp.last  = (m == deg);
            expected_components.push_back(comp);
        end
    endfunction

    task automatic note_failure(input t_component want, input t_component got,
                                input bit orphan);
        fail_total++;
        if (fail_total <= 10) begin
            if (orphan) begin
                $display("unexpected result: freq %0d m %0d last %0b",
                         got.freq, got.order, got.last);
            end else begin
                $display("mismatch: freq exp %0d got %0d, m exp %0d got %0d, last exp %0b got %0b",
                         want.freq, got.freq, want.order, got.order, want.last, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                seen.freq  = i_res_data[FREQ_W-1:0];
                seen.order = i_res_data[FREQ_W +: ORD_W];
                seen.last  = i_res_last;
                if (expected_components.size() == 0) begin
                    note_failure(seen, seen, 1'b1);
                end else begin
                    wanted = expected_components.pop_front();
                    if (seen.freq != wanted.freq || seen.order != wanted.order
                            || seen.last != wanted.last) begin
                        note_failure(wanted, seen, 1'b0);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                split_components(i_req_data);
            end
            o_pending    <= expected_components.size();
            o_fail_count <= fail_total;
        end
    end

endmodule

@@ bench/mode_frequencies_from_acoefs_tb.sv @@
// testbench top for mode_frequencies_from_acoefs: directed and random mode requests
// with random idling on both channels; verdict from mfa_split_checker
// depends on mfa_pkg, mfa_split_checker and the block itself
module mode_frequencies_from_acoefs_tb;
    import mfa_pkg::*;

    localparam int                COEFS_W     = NUM_TERMS * FREQ_W;
    localparam int                CYCLE_LIMIT = 500000;
    localparam int                SETTLE      = 120;
    localparam logic [FREQ_W-1:0] FREQ_MAX    = {1'b0, {(FREQ_W - 1){1'b1}}};
    localparam logic [FREQ_W-1:0] FREQ_MIN    = {1'b1, {(FREQ_W - 1){1'b0}}};

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // central_freq, degree, coef_a1 .. coef_a6, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // split_freq, azimuthal_order, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int pending;
    int fail_count;
    int tx_idle_pct = 27;
    int rx_idle_pct = 27;
    int cycle_count = 0;

    mode_frequencies_from_acoefs u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mfa_split_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("mode_frequencies_from_acoefs regression: fail");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // mix of full range, small, mid-range and extreme fixed-point values
    function automatic logic [FREQ_W-1:0] rand_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3: return raw[FREQ_W-1:0];
            4, 5: return FREQ_W'($signed($urandom_range(2000)) - 1000);
            6, 7: return FREQ_W'($signed(raw[31:0]));
            8: begin
                case ($urandom_range(3))
                    0: return FREQ_MAX;
                    1: return FREQ_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return FREQ_W'($signed(raw[39:0]));
        endcase
    endfunction

    task automatic send_mode(input logic [FREQ_W-1:0] nu0, input logic [DEG_W-1:0] degree,
                             input logic [COEFS_W-1:0] coefs);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({coefs, degree, nu0});
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_random(input int count);
        logic [COEFS_W-1:0] coefs;
        for (int i = 0; i < count; i++) begin
            for (int s = 0; s < NUM_TERMS; s++) begin
                coefs[s * FREQ_W +: FREQ_W] = rand_value();
            end
            send_mode(rand_value(), DEG_W'($urandom_range(3)), coefs);
        end
    endtask

    initial begin
        logic [COEFS_W-1:0] coefs;
        logic [FREQ_W-1:0]  small_val;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every degree with unit coefficients
        for (int d = 0; d < 4; d++) begin
            send_mode(rand_value(), DEG_W'(d), {NUM_TERMS{FREQ_W'(1)}});
        end
        // extremes of the central frequency and all coefficients
        send_mode(FREQ_MAX, 2'd0, {NUM_TERMS{FREQ_MAX}});
        send_mode(FREQ_MIN, 2'd0, {NUM_TERMS{FREQ_MIN}});
        send_mode(FREQ_MAX, 2'd3, {NUM_TERMS{FREQ_MAX}});
        send_mode(FREQ_MIN, 2'd3, {NUM_TERMS{FREQ_MIN}});
        send_mode(FREQ_MAX, 2'd1, {NUM_TERMS{FREQ_MIN}});
        send_mode(FREQ_MIN, 2'd2, {NUM_TERMS{FREQ_MAX}});
        // each coefficient alone at an extreme
        for (int s = 0; s < NUM_TERMS; s++) begin
            coefs = '0;
            coefs[s * FREQ_W +: FREQ_W] = (s % 2) ? FREQ_MIN : FREQ_MAX;
            send_mode('0, 2'd3, coefs);
        end
        // each coefficient alone and small, for rounding ties
        for (int s = 0; s < NUM_TERMS; s++) begin
            coefs     = '0;
            small_val = FREQ_W'($urandom_range(1, 9));
            coefs[s * FREQ_W +: FREQ_W] = $urandom_range(1) ? -small_val : small_val;
            send_mode(FREQ_W'($urandom_range(255)), DEG_W'(2 + s % 2), coefs);
        end
        drain_results();

        send_random(200);
        // stretch without idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(100);
        drain_results();
        tx_idle_pct = 27;
        rx_idle_pct = 27;
        send_random(200);
        drain_results();

        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("mode_frequencies_from_acoefs regression: pass");
        end else begin
            $display("mode_frequencies_from_acoefs regression: fail");
        end
        $finish;
    end

endmodule

@@ mode_frequencies_from_acoefs.f @@
hw/rtl/mfa_pkg.sv
hw/rtl/mode_frequencies_from_acoefs.sv
bench/mfa_split_checker.sv
bench/mode_frequencies_from_acoefs_tb.sv
